// ===== hw/rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, codes and helper functions of the infix-to-postfix block.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CODE_W      = 3;
    localparam int SYM_W       = 8;

    // operator codes held on the stack
    localparam logic [CODE_W-1:0] CODE_LPAREN = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ADD    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SUB    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_MUL    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DIV    = 3'd4;
    localparam logic [CODE_W-1:0] CODE_MOD    = 3'd5;
    localparam logic [CODE_W-1:0] CODE_POW    = 3'd6;
    localparam logic [CODE_W-1:0] CODE_NONE   = 3'd7;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ALNUM,
        KIND_LPAR,
        KIND_RPAR,
        KIND_OP,
        KIND_END
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_TERM
    } state_t;

    function automatic logic [CODE_W-1:0] op_code(input logic [SYM_W-1:0] c);
        case (c)
            "+":     op_code = CODE_ADD;
            "-":     op_code = CODE_SUB;
            "*":     op_code = CODE_MUL;
            "/":     op_code = CODE_DIV;
            "%":     op_code = CODE_MOD;
            "^":     op_code = CODE_POW;
            default: op_code = CODE_NONE;
        endcase
    endfunction

    function automatic logic [1:0] prec(input logic [CODE_W-1:0] code);
        case (code)
            CODE_ADD, CODE_SUB:           prec = 2'd1;
            CODE_MUL, CODE_DIV, CODE_MOD: prec = 2'd2;
            CODE_POW:                     prec = 2'd3;
            default:                      prec = 2'd0;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] code_char(input logic [CODE_W-1:0] code);
        case (code)
            CODE_LPAREN: code_char = "(";
            CODE_ADD:    code_char = "+";
            CODE_SUB:    code_char = "-";
            CODE_MUL:    code_char = "*";
            CODE_DIV:    code_char = "/";
            CODE_MOD:    code_char = "%";
            CODE_POW:    code_char = "^";
            default:     code_char = '0;
        endcase
    endfunction

    function automatic logic is_alnum(input logic [SYM_W-1:0] c);
        is_alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z");
    endfunction

endpackage

// ===== hw/rtl/itp_stack_ram.sv =====
// ----------------------------------------------------------------------------
// itp_stack_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module itp_stack_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 3,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream to postfix.
// ----------------------------------------------------------------------------
// One ASCII character comes in per transfer on the s_ side; s_tlast marks the
// end of an expression. Letters and digits go straight out; '(' and operators
// are kept on a 16-entry operator stack held in a RAM with a registered read.
// Handling: a letter, digit, '(' or ignored character is finished when it is
// accepted. A ')', an operator or an end marker is accepted, then the stack
// entries it inspects are read one by one: each popped entry (the read of the
// next entry overlaps the pop) and then the entry that stops the pops, a '('
// or an operator of lower precedence, where there is one. An operator on an
// empty stack is pushed in its accept cycle. The end marker's pops are followed
// by its terminating transfer. The single read port of the stack RAM limits
// the stack to one pop per cycle while m_tready does not hold off a waiting
// result; a held-off result stalls the pops. The terminating transfer carries
// m_tlast = 1, m_tdata = 0 and m_tuser = 1 if any push onto a full stack was
// dropped since the previous end marker. The RAM is not cleared at reset:
// only entries below the stack count are ever read.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // expr_end
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_symbol
    output logic       m_tlast,   // last
    output logic [0:0] m_tuser    // [0] overflow
);

    // ---- state registers ----
    itp_pkg::state_t                   state_reg, state_next;
    logic [itp_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                              ovf_reg, ovf_next;
    itp_pkg::kind_t                    kind_reg, kind_next;
    logic [itp_pkg::CODE_W-1:0]        op_reg, op_next;

    // ---- output register ----
    logic                              m_valid_reg, m_valid_next;
    logic [itp_pkg::SYM_W-1:0]         m_sym_reg, m_sym_next;
    logic                              m_last_reg, m_last_next;
    logic                              m_ovf_reg, m_ovf_next;

    // ---- stack RAM ports ----
    logic                              wr_en;
    logic [itp_pkg::ADDR_W-1:0]        wr_addr;
    logic [itp_pkg::CODE_W-1:0]        wr_data;
    logic                              rd_en;
    logic [itp_pkg::ADDR_W-1:0]        rd_addr;
    logic [itp_pkg::CODE_W-1:0]        top_code;

    // ---- control helpers ----
    logic                              out_free;
    logic                              s_xfer;
    itp_pkg::kind_t                    in_kind;
    logic [itp_pkg::CODE_W-1:0]        in_code;
    logic [itp_pkg::CNT_W-1:0]         cnt_m1, cnt_m2, push_base;
    logic [itp_pkg::CNT_W-1:0]         push_cnt;
    logic                              push_req;
    logic [itp_pkg::CODE_W-1:0]        push_code;
    logic                              pop_cond;
    logic                              emit;
    logic [itp_pkg::SYM_W-1:0]         emit_sym;
    logic                              emit_last;
    logic                              emit_ovf;

    itp_stack_ram #(
        .DEPTH  (itp_pkg::STACK_DEPTH),
        .WIDTH  (itp_pkg::CODE_W),
        .ADDR_W (itp_pkg::ADDR_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (top_code)
    );

    // output slot can take a new result this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == itp_pkg::ST_IDLE) && out_free;
    assign s_xfer   = s_tvalid && s_tready;

    assign cnt_m1   = cnt_reg - itp_pkg::CNT_W'(1);
    assign cnt_m2   = cnt_reg - itp_pkg::CNT_W'(2);
    assign push_cnt = push_base + itp_pkg::CNT_W'(1);

    // classify the incoming character
    always_comb begin
        in_code = itp_pkg::op_code(s_tdata);
        if (s_tlast) begin
            in_kind = itp_pkg::KIND_END;
        end else if (itp_pkg::is_alnum(s_tdata)) begin
            in_kind = itp_pkg::KIND_ALNUM;
        end else if (s_tdata == "(") begin
            in_kind = itp_pkg::KIND_LPAR;
        end else if (s_tdata == ")") begin
            in_kind = itp_pkg::KIND_RPAR;
        end else if (in_code != itp_pkg::CODE_NONE) begin
            in_kind = itp_pkg::KIND_OP;
        end else begin
            in_kind = itp_pkg::KIND_NONE;
        end
    end

    // does the entry now on top get popped for the pending character
    always_comb begin
        case (kind_reg)
            itp_pkg::KIND_END:  pop_cond = 1'b1;
            itp_pkg::KIND_RPAR: pop_cond = (top_code != itp_pkg::CODE_LPAREN);
            itp_pkg::KIND_OP:   pop_cond = itp_pkg::prec(top_code) >= itp_pkg::prec(op_reg);
            default:            pop_cond = 1'b0;
        endcase
    end

    // next state and datapath control
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        kind_next  = kind_reg;
        op_next    = op_reg;
        rd_en      = 1'b0;
        rd_addr    = cnt_m1[itp_pkg::ADDR_W-1:0];
        push_req   = 1'b0;
        push_base  = cnt_reg;
        push_code  = op_reg;
        emit       = 1'b0;
        emit_sym   = '0;
        emit_last  = 1'b0;
        emit_ovf   = 1'b0;

        case (state_reg)
            itp_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    kind_next = in_kind;
                    op_next   = in_code;
                    case (in_kind)
                        itp_pkg::KIND_ALNUM: begin
                            emit     = 1'b1;
                            emit_sym = s_tdata;
                        end
                        itp_pkg::KIND_LPAR: begin
                            push_req  = 1'b1;
                            push_code = itp_pkg::CODE_LPAREN;
                        end
                        itp_pkg::KIND_RPAR: begin
                            if (cnt_reg != '0) begin
                                rd_en      = 1'b1;
                                state_next = itp_pkg::ST_POP;
                            end
                        end
                        itp_pkg::KIND_OP: begin
                            if (cnt_reg != '0) begin
                                rd_en      = 1'b1;
                                state_next = itp_pkg::ST_POP;
                            end else begin
                                push_req  = 1'b1;
                                push_code = in_code;
                            end
                        end
                        itp_pkg::KIND_END: begin
                            if (cnt_reg != '0) begin
                                rd_en      = 1'b1;
                                state_next = itp_pkg::ST_POP;
                            end else begin
                                state_next = itp_pkg::ST_TERM;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // top_code holds the entry at cnt_reg - 1
            itp_pkg::ST_POP: begin
                if (pop_cond) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        emit_sym = itp_pkg::code_char(top_code);
                        cnt_next = cnt_m1;
                        if (cnt_m1 == '0) begin
                            case (kind_reg)
                                itp_pkg::KIND_END: state_next = itp_pkg::ST_TERM;
                                itp_pkg::KIND_OP: begin
                                    push_req   = 1'b1;
                                    push_base  = cnt_m1;
                                    state_next = itp_pkg::ST_IDLE;
                                end
                                default: state_next = itp_pkg::ST_IDLE;
                            endcase
                        end else begin
                            // fetch the next entry down while popping this one
                            rd_en   = 1'b1;
                            rd_addr = cnt_m2[itp_pkg::ADDR_W-1:0];
                        end
                    end
                end else if (kind_reg == itp_pkg::KIND_RPAR) begin
                    // matching '(' is discarded
                    cnt_next   = cnt_m1;
                    state_next = itp_pkg::ST_IDLE;
                end else begin
                    push_req   = 1'b1;
                    state_next = itp_pkg::ST_IDLE;
                end
            end

            itp_pkg::ST_TERM: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_ovf   = ovf_reg;
                    ovf_next   = 1'b0;
                    state_next = itp_pkg::ST_IDLE;
                end
            end

            default: state_next = itp_pkg::ST_IDLE;
        endcase

        // push; dropped with sticky overflow when the stack is full
        wr_en   = 1'b0;
        wr_addr = push_base[itp_pkg::ADDR_W-1:0];
        wr_data = push_code;
        if (push_req) begin
            if (push_base == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH)) begin
                ovf_next = 1'b1;
            end else begin
                wr_en    = 1'b1;
                cnt_next = push_cnt;
            end
        end
    end

    // output register next value
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_sym_next   = m_sym_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_sym_next   = emit_sym;
            m_last_next  = emit_last;
            m_ovf_next   = emit_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= itp_pkg::ST_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        op_reg     <= op_next;
        m_sym_reg  <= m_sym_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_sym_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ovf_reg;

endmodule
